### rtl/core/sha256_stream_hasher_defines.svh
// Assertion macros shared by the checker.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sha256 check failed");
`define SHA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sha256 check failed");
`endif

### rtl/core/sha_pkg.sv
package sha_pkg;
    localparam int unsigned WORD_W = 32;

    typedef logic [WORD_W-1:0] t_word;

    // queue entry between front and back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } t_item;

    localparam t_word INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction
endpackage

### rtl/core/sha_front.sv
// Skid-free two-entry queue; accept items, drop idle ones.
module sha_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sha_pkg::t_item i_item,
    output logic           o_q_valid,
    input  logic           i_q_ready,
    output sha_pkg::t_item o_q_item
);
    import sha_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready && (i_item.has_byte || i_item.last);
    assign o_q_valid = (r_cnt != 2'd0);
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_item;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

### rtl/core/sha_back.sv
// Byte packer, padder, round engine and digest emitter.
module sha_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_ready,
    input  sha_pkg::t_item i_q_item,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_digest_word,
    output logic [2:0]     o_word_index,
    output logic           o_digest_last
);
    import sha_pkg::*;

    typedef enum logic [4:0] {
        ST_TAKE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    t_state      r_st, n_st;
    t_word       r_h [8];
    t_word       r_v [8];
    t_word       r_w [16];
    t_word       r_asm;
    logic [63:0] r_bits, r_len;
    logic [6:0]  r_rnd;
    logic [5:0]  r_pos;      // padding byte position
    logic        r_pad;      // padding in progress
    logic        r_first;    // 0x80 not yet placed
    logic        r_lenblk;   // length goes into the current block
    logic [2:0]  r_oi;

    // position of the 0x80 byte when the last item is taken
    logic [5:0]  tail_pos;
    assign tail_pos = r_bits[8:3] + {5'd0, i_q_item.has_byte};

    // byte source
    logic [7:0]  pb;
    logic        push;
    logic [5:0]  bpos;
    always_comb begin
        pb   = i_q_item.data_byte;
        bpos = r_bits[8:3];
        push = 1'b0;
        o_q_ready = 1'b0;
        if (r_st == ST_TAKE) begin
            o_q_ready = 1'b1;
            push = i_q_valid && i_q_item.has_byte;
        end else if (r_st == ST_PAD) begin
            push = 1'b1;
            bpos = r_pos;
            if (r_first) pb = PAD_BYTE;
            else if (r_lenblk && r_pos >= LEN_POS) pb = r_len[8*(7-(r_pos[2:0]))+:8];
            else pb = 8'h00;
        end
    end

    // schedule and round
    logic [3:0] ri;
    t_word w2, w7, w15, w16, s0, s1, wn, wr, t1, t2, a, e;
    always_comb begin
        ri  = r_rnd[3:0];
        w2  = r_w[ri - 4'd2];
        w7  = r_w[ri - 4'd7];
        w15 = r_w[ri - 4'd15];
        w16 = r_w[ri];
        s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        wn  = s1 + w7 + s0 + w16;
        wr  = (r_rnd < 7'd16) ? w16 : wn;
        a   = r_v[0];
        e   = r_v[4];
        t1  = r_v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & r_v[5]) ^ (~e & r_v[6])) + ROUND_K[r_rnd[5:0]] + wr;
        t2  = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    logic blk_full;
    assign blk_full = push && (bpos == 6'd63);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_TAKE: if (blk_full) n_st = ST_ROUND;
                     else if (i_q_valid && i_q_item.last) n_st = ST_PAD;
            ST_PAD:  if (blk_full) n_st = ST_ROUND;
                     else if (!r_first && r_pos == 6'd63) n_st = ST_ADD;
            ST_ROUND: if (r_rnd == 7'd63) n_st = ST_ADD;
            ST_ADD:  n_st = r_pad ? (r_lenblk && !r_first ? ST_OUT : ST_PAD) : ST_TAKE;
            ST_OUT:  if (i_ready && r_oi == 3'd7) n_st = ST_TAKE;
            default: n_st = ST_TAKE;
        endcase
    end

    assign o_valid       = (r_st == ST_OUT);
    assign o_digest_word = r_h[r_oi];
    assign o_word_index  = r_oi;
    assign o_digest_last = (r_oi == 3'd7);

    always_ff @(posedge i_clk) begin
        if (push && bpos[1:0] == 2'd3) r_w[bpos[5:2]] <= {r_asm[23:0], pb};
        if (r_st == ST_ROUND && r_rnd >= 7'd16) r_w[ri] <= wn;
        if (!i_rst_n) begin
            r_st <= ST_TAKE;
            r_h <= INIT_HASH;
            for (int i = 0; i < 8; i++) r_v[i] <= '0;
            r_asm <= '0; r_bits <= '0; r_len <= '0; r_rnd <= '0;
            r_pos <= '0; r_pad <= 1'b0; r_first <= 1'b0; r_lenblk <= 1'b0; r_oi <= '0;
        end else begin
            r_st <= n_st;
            if (push) r_asm <= (bpos[1:0] == 2'd3) ? '0 : {r_asm[23:0], pb};
            if (r_st == ST_TAKE && push) r_bits <= r_bits + 64'd8;
            if (r_st == ST_TAKE && i_q_valid && i_q_item.last) begin
                r_pad    <= 1'b1;
                r_first  <= 1'b1;
                r_len    <= r_bits + (i_q_item.has_byte ? 64'd8 : 64'd0);
                r_pos    <= tail_pos;
                r_lenblk <= (tail_pos < LEN_POS);
            end
            if (r_st == ST_PAD) begin
                r_first <= 1'b0;
                r_pos   <= r_pos + 6'd1;
            end
            if (blk_full) begin
                r_v <= r_h;
                r_rnd <= '0;
            end
            if (r_st == ST_ROUND) begin
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_rnd <= r_rnd + 7'd1;
            end
            if (r_st == ST_ADD) begin
                r_rnd <= '0;
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                if (r_pad) r_lenblk <= 1'b1;
                if (r_pad && r_lenblk && !r_first) r_oi <= '0;
            end
            if (r_st == ST_OUT && i_ready) begin
                r_oi <= r_oi + 3'd1;
                if (r_oi == 3'd7) begin
                    r_h <= INIT_HASH;
                    for (int i = 0; i < 8; i++) r_v[i] <= '0;
                    r_asm <= '0; r_bits <= '0; r_pad <= 1'b0;
                end
            end
        end
    end
endmodule

### rtl/core/sha256_stream_hasher.sv
// SHA-256 over a byte stream; eight digest words per message.
// Throughput: bytes enter a 2-deep queue at one per cycle while it has room;
// each 64-byte block then runs through the round engine and a chaining add.
// After the last item: padding bytes, one or two compressions, then eight
// output words at one per cycle while i_ready is high.
// Reset: i_rst_n synchronous, active low; loads the standard initial hash.
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_digest_last
);
    import sha_pkg::*;

    t_item in_item, q_item;
    logic  q_valid, q_ready;

    assign in_item = '{data_byte: i_data_byte, has_byte: i_has_byte, last: i_last};

    // front: accept and drop idle items
    sha_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item(in_item),
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_item(q_item)
    );

    // back: pack, pad, compress, emit
    sha_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_item(q_item),
        .o_valid, .i_ready, .o_digest_word, .o_word_index, .o_digest_last
    );
endmodule

### rtl/core/sha_checker.sv
`include "sha256_stream_hasher_defines.svh"
module sha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_digest_last
);
    `SHA_ASSERT_IMP(a_last_idx, i_clk, i_rst_n, o_valid, o_digest_last == (o_word_index == 3'd7))
    `SHA_ASSERT_NXT(a_idx_step, i_clk, i_rst_n, o_valid && i_ready && !o_digest_last, o_valid && o_word_index == $past(o_word_index) + 3'd1)
    `SHA_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_digest_word))
endmodule

bind sha256_stream_hasher sha_checker u_chk (.*);

### bench/sha256_digest_checker.sv
module sha256_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_digest_word,
    input  logic [2:0]  i_word_index,
    input  logic        i_digest_last,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sha_pkg::*;

    typedef struct {
        t_word      word;
        logic [2:0] index;
        logic       last_flag;
    } t_digest_exp;

    t_digest_exp digest_q[$];
    t_word       hash_state [8];
    t_word       msg_window [16];
    t_word       word_acc;
    logic [63:0] bit_count;
    int          mismatches;

    function automatic t_word ror(input t_word x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    task automatic clear_hash();
        hash_state = INIT_HASH;
        word_acc = '0;
        bit_count = '0;
    endtask

    // run 64 rounds on the window, schedule expanded in place
    task automatic compress();
        t_word v [8];
        t_word w, t1, t2, s0, s1;
        v = hash_state;
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                w = msg_window[r];
            end else begin
                s0 = ror(msg_window[(r-15)&15], 7) ^ ror(msg_window[(r-15)&15], 18)
                     ^ (msg_window[(r-15)&15] >> 3);
                s1 = ror(msg_window[(r-2)&15], 17) ^ ror(msg_window[(r-2)&15], 19)
                     ^ (msg_window[(r-2)&15] >> 10);
                w = s1 + msg_window[(r-7)&15] + s0 + msg_window[r&15];
                msg_window[r&15] = w;
            end
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w;
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    task automatic place_byte(input logic [7:0] b, input int pos);
        word_acc = {word_acc[23:0], b};
        if ((pos & 3) == 3) begin
            msg_window[pos >> 2] = word_acc;
            word_acc = '0;
        end
        if (pos == 63) compress();
    endtask

    task automatic absorb_item(input logic [7:0] b, input logic hb, input logic lst);
        logic [63:0] len;
        int pos;
        t_digest_exp e;
        if (hb) begin
            place_byte(b, int'(bit_count[8:3]));
            bit_count += 64'd8;
        end
        if (lst) begin
            len = bit_count;
            pos = int'(len[8:3]);
            place_byte(PAD_BYTE, pos);
            pos = (pos + 1) & 63;
            while (pos != int'(LEN_POS)) begin
                place_byte(8'h00, pos);
                pos = (pos + 1) & 63;
            end
            for (int k = 7; k >= 0; k--) begin
                place_byte(len[k*8 +: 8], pos);
                pos = (pos + 1) & 63;
            end
            for (int k = 0; k < 8; k++) begin
                e.word = hash_state[k];
                e.index = 3'(k);
                e.last_flag = (k == 7);
                digest_q.push_back(e);
            end
            clear_hash();
        end
    endtask

    initial begin
        mismatches = 0;
        clear_hash();
    end

    assign o_fail_count = mismatches;
    assign o_pending = digest_q.size();

    always @(posedge i_clk) begin
        t_digest_exp e;
        if (!i_rst_n) begin
            clear_hash();
        end else begin
            if (i_valid && i_ready_in) absorb_item(i_data_byte, i_has_byte, i_last);
            if (i_out_valid && i_out_ready) begin
                if (digest_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected digest word %h idx %0d", i_digest_word,
                                 i_word_index);
                end else begin
                    e = digest_q.pop_front();
                    if (e.word !== i_digest_word || e.index !== i_word_index
                        || e.last_flag !== i_digest_last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     e.word, e.index, e.last_flag, i_digest_word,
                                     i_word_index, i_digest_last);
                    end
                end
            end
        end
    end
endmodule

### bench/sha256_stream_hasher_tb.sv
module sha256_stream_hasher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_has_byte;
    logic        i_last;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_digest_last;
    int          fail_count;
    int          pending;
    int          cycle_count;
    bit          calm_phase;
    bit          hold_off;

    localparam int CYCLE_LIMIT = 400000;

    sha256_stream_hasher u_top (.*);

    sha256_digest_checker u_chk (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready), .i_data_byte,
        .i_has_byte, .i_last, .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_digest_word(o_digest_word), .i_word_index(o_word_index),
        .i_digest_last(o_digest_last), .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // watchdog: give up well past the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sha256_stream_hasher test failed");
            $finish;
        end
    end

    // receiver: random stalls, none in the calm phase, a long hold-off once
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else if (hold_off) i_ready <= 1'b0;
        else i_ready <= calm_phase || ($urandom_range(99) >= 20);
    end

    initial begin
        hold_off = 1'b0;
        wait (i_rst_n);
        repeat (1500) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // offer one item; hold it until accepted, idle at random first
    task automatic send_item(input logic [7:0] b, input logic hb, input logic lst);
        while (!calm_phase && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_has_byte <= hb;
        i_last <= lst;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_message(input int len, input bit empty_tail, input int fill);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            // fill: 0 random, 1 all ones, 2 all zeros
            b = (fill == 1) ? 8'hff : (fill == 2) ? 8'h00 : 8'($urandom);
            if ($urandom_range(15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(b, 1'b1, !empty_tail && (i == len - 1));
        end
        if (empty_tail || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int sent;
        int len;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = '0;
        i_has_byte = 1'b0;
        i_last = 1'b0;
        calm_phase = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty message, single bytes at the extremes, ignored item,
        // padding boundaries at 55/56 bytes, empty tail after data
        send_message(0, 1'b0, 0);
        send_message(1, 1'b0, 1);
        send_message(1, 1'b0, 2);
        send_item(8'hff, 1'b0, 1'b0);
        send_message(3, 1'b1, 0);
        send_message(55, 1'b0, 1);
        send_message(56, 1'b0, 2);

        // random messages, mostly short, a block or more (64 to 130 bytes) now and then
        sent = 0;
        while (sent < 480) begin
            calm_phase = (sent > 200 && sent < 300);
            case ($urandom_range(3))
                0: len = $urandom_range(64, 130);
                default: len = $urandom_range(0, 20);
            endcase
            send_message(len, $urandom_range(3) == 0, 0);
            sent += len + 1;
        end
        i_valid <= 1'b0;
        calm_phase = 1'b0;

        // let the checker take in the final item before watching the queue
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("sha256_stream_hasher test passed");
        else
            $display("sha256_stream_hasher test failed");
        $finish;
    end
endmodule
